### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted array priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 8;

  localparam logic signed [KEY_W-1:0] EMPTY_KEY = -32'sd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PEEK   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // command broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

  // what the cell row tells the controller
  typedef struct packed {
    logic                    empty;
    logic                    full;
    logic signed [KEY_W-1:0] tail_key;
  } queue_stat_t;

endpackage

### hw/rtl/spq_in_if.sv
// ----------------------------------------------------------------------------
// spq_in_if
// Operation channel: kind and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_in_if;
  import spq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic signed [KEY_W-1:0] key_in;

  modport source (output valid, kind, key_in, input ready);
  modport sink (input valid, kind, key_in, output ready);

endinterface

### hw/rtl/spq_out_if.sv
// ----------------------------------------------------------------------------
// spq_out_if
// Result channel: served key, status and occupancy, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_out_if;
  import spq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key_out;
  logic [STATUS_W-1:0]     status;
  logic [OCC_W-1:0]        occupancy;

  modport source (output valid, key_out, status, occupancy, input ready);
  modport sink (input valid, key_out, status, occupancy, output ready);

endinterface

### hw/rtl/sorted_array_priority_queue.sv
// Each result word is registered as its operation word is accepted; every cell compares
// and shifts in the same cycle. Throughput: one operation per cycle unless out_o stalls.
// The served key always comes from cell 0, so remove and peek cost the same as insert.
// Reset clears the cell valid bits, the count and the output valid bit; stored keys
// are not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Priority queue of signed keys kept sorted in a row of shifting cells;
// serves the smallest key.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  cell_cmd_t               cmd;
  queue_stat_t             stat;
  logic [CNT_W-1:0]        count;
  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]     cell_valid;
  logic [CAPACITY-1:0]     cell_gt;
  logic [CAPACITY-1:0]     cell_le;

  spq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_kind_i       (in_i.kind),
    .in_key_i        (in_i.key_in),
    .in_ready_o      (in_i.ready),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_key_o       (out_o.key_out),
    .out_status_o    (out_o.status),
    .out_occupancy_o (out_o.occupancy),
    .stat_i          (stat),
    .cmd_o           (cmd),
    .count_o         (count)
  );

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic signed [KEY_W-1:0] lo_key, hi_key;
    logic                    lo_gt, lo_le, hi_valid;

    if (j == 0) begin : g_bottom
      assign lo_key = '0;
      assign lo_gt  = 1'b0;
      assign lo_le  = 1'b1;
    end else begin : g_lower
      assign lo_key = cell_key[j-1];
      assign lo_gt  = cell_gt[j-1];
      assign lo_le  = cell_le[j-1];
    end

    if (j == CAPACITY - 1) begin : g_top
      assign hi_key   = '0;
      assign hi_valid = 1'b0;
    end else begin : g_upper
      assign hi_key   = cell_key[j+1];
      assign hi_valid = cell_valid[j+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .lo_key_i   (lo_key),
      .lo_gt_i    (lo_gt),
      .lo_le_i    (lo_le),
      .hi_key_i   (hi_key),
      .hi_valid_i (hi_valid),
      .key_o      (cell_key[j]),
      .valid_o    (cell_valid[j]),
      .gt_o       (cell_gt[j]),
      .le_o       (cell_le[j])
    );
  end

  assign stat.empty    = !cell_valid[0];
  assign stat.full     = cell_valid[CAPACITY-1];
  assign stat.tail_key = cell_key[0];

  // occupied cells form one run starting at cell 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid + CAPACITY'(1)) & cell_valid) == '0)
    else $error("occupied cells are not contiguous from the tail");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count))
    else $error("cell valid bits disagree with the stored count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.occupancy == OCC_W'(count)))
    else $error("reported occupancy differs from the stored count");

  for (genvar j = 1; j < CAPACITY; j++) begin : g_order_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      cell_valid[j] |-> (cell_key[j] >= cell_key[j-1]))
      else $error("cell row out of order");
  end

endmodule

### hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row. Cell 0 holds the tail (smallest key); larger
// keys sit at higher cells. Insert shifts larger keys up one cell, remove
// shifts the whole row down one cell.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  spq_pkg::cell_cmd_t              cmd_i,
  input  logic signed [spq_pkg::KEY_W-1:0] lo_key_i,
  input  logic                            lo_gt_i,
  input  logic                            lo_le_i,
  input  logic signed [spq_pkg::KEY_W-1:0] hi_key_i,
  input  logic                            hi_valid_i,
  output logic signed [spq_pkg::KEY_W-1:0] key_o,
  output logic                            valid_o,
  output logic                            gt_o,
  output logic                            le_o
);
  import spq_pkg::*;

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    valid_q, valid_d;

  // stored key strictly above the new key moves up; equal keys stay below it
  assign gt_o = valid_q && (key_q > cmd_i.key);
  assign le_o = valid_q && !(key_q > cmd_i.key);

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (cmd_i.ins) begin
      if (lo_gt_i) begin
        key_d   = lo_key_i;
        valid_d = 1'b1;
      end else if (!le_o && lo_le_i) begin
        key_d   = cmd_i.key;
        valid_d = 1'b1;
      end
    end else if (cmd_i.rem) begin
      key_d   = hi_key_i;
      valid_d = hi_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule

### hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Decodes each operation word, drives the cell row command, keeps the count
// and holds the result word in an output register.
// ----------------------------------------------------------------------------
module spq_ctrl #(
  parameter int unsigned CAPACITY = 128,
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic [spq_pkg::KIND_W-1:0]         in_kind_i,
  input  logic signed [spq_pkg::KEY_W-1:0]   in_key_i,
  output logic                               in_ready_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [spq_pkg::KEY_W-1:0]   out_key_o,
  output logic [spq_pkg::STATUS_W-1:0]       out_status_o,
  output logic [spq_pkg::OCC_W-1:0]          out_occupancy_o,
  input  spq_pkg::queue_stat_t               stat_i,
  output spq_pkg::cell_cmd_t                 cmd_o,
  output logic [CNT_W-1:0]                   count_o
);
  import spq_pkg::*;

  logic                    accept;
  logic                    out_valid_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  status_e                 status_q, status_d;
  logic [OCC_W-1:0]        occ_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o     = '0;
    cmd_o.key = in_key_i;
    key_d     = '0;
    status_d  = ST_OK;
    count_d   = count_q;
    if (accept) begin
      unique case (in_kind_i) inside
        KIND_INSERT: begin
          if (stat_i.full) begin
            status_d = ST_FULL;
          end else begin
            cmd_o.ins = 1'b1;
            count_d   = CNT_W'(count_q + CNT_W'(1));
          end
        end
        KIND_REMOVE, KIND_PEEK: begin
          if (stat_i.empty) begin
            key_d    = EMPTY_KEY;
            status_d = ST_EMPTY;
          end else begin
            key_d = stat_i.tail_key;
            if (in_kind_i == KIND_REMOVE) begin
              cmd_o.rem = 1'b1;
              count_d   = CNT_W'(count_q - CNT_W'(1));
            end
          end
        end
        default: begin
          // unused kind: no operation
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (in_ready_o) begin
        out_valid_q <= accept;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q    <= key_d;
      status_q <= status_d;
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_key_o       = key_q;
  assign out_status_o    = status_q;
  assign out_occupancy_o = occ_q;
  assign count_o         = count_q;

endmodule
